### src/mswd_pkg.sv
package mswd_pkg;

   // elaboration defaults for the top level parameters
   localparam int DEF_MAX_SWITCHES = 16;
   localparam int DEF_TIME_BITS    = 32;

   // field widths
   localparam int INDEX_W    = 4;
   localparam int NOTE_W     = 8;
   localparam int VELOCITY_W = 7;
   localparam int CHANNEL_W  = 8;
   localparam int DEBOUNCE_W = 16;
   localparam int FIRST_W    = 7;
   localparam int COUNT_W    = 5;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE_MS  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_NOTE   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIDI_CHANNEL = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SWITCH_COUNT = 2'd3;

   // register reset values
   localparam logic [DEBOUNCE_W-1:0] RST_DEBOUNCE_MS  = 16'd50;
   localparam logic [FIRST_W-1:0]    RST_FIRST_NOTE   = 7'd36;
   localparam logic [CHANNEL_W-1:0]  RST_MIDI_CHANNEL = 8'd1;
   localparam logic [COUNT_W-1:0]    RST_SWITCH_COUNT = 5'd16;

   // request opcodes
   localparam logic OP_TICK   = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;

   localparam logic LEVEL_LOW = 1'b0;
   localparam logic [VELOCITY_W-1:0] FIXED_VELOCITY = 7'd127;

endpackage

### src/mswd_req_if.sv
interface mswd_req_if;
   logic                          valid;
   logic                          ready;
   logic                          op;
   logic [mswd_pkg::INDEX_W-1:0]  switch_index;
   logic                          level;

   modport source (output valid, output op, output switch_index, output level, input ready);
   modport sink   (input valid, input op, input switch_index, input level, output ready);
endinterface

### src/mswd_rsp_if.sv
interface mswd_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [mswd_pkg::NOTE_W-1:0]      note_number;
   logic                             note_on;
   logic [mswd_pkg::VELOCITY_W-1:0]  velocity;
   logic [mswd_pkg::CHANNEL_W-1:0]   channel;

   modport source (output valid, output note_number, output note_on, output velocity,
                   output channel, input ready);
   modport sink   (input valid, input note_number, input note_on, input velocity,
                   input channel, output ready);
endinterface

### src/multi_switch_debounce_note_events.sv
// Debounces up to MAX_SWITCHES pad switches and turns accepted level changes
// into note events. A tick request advances a TIME_BITS wide millisecond
// counter; a sample request carries one switch index and its level. A change
// is taken when more than debounce_ms has passed since that switch's last
// taken change and the level differs from the stored one; it gives one event
// (note on for a low level, note off for a high level, velocity 127). The
// block takes one request per clock unless stage one is stalled. A request
// first reads the per-switch level and timestamp from the switch memory into
// stage one; the lockout compare then writes the result register. A waiting
// result stalls only requests that would produce a result. Stored state
// starts as level low, timestamp zero, through per-switch valid bits that
// reset clears at once, so there is no clearing pass after reset. Configuration
// must be written only while the block is idle; the block itself does not enforce it.
module multi_switch_debounce_note_events #(
   parameter int MAX_SWITCHES = mswd_pkg::DEF_MAX_SWITCHES,
   parameter int TIME_BITS    = mswd_pkg::DEF_TIME_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   mswd_req_if.sink                          req_ch,
   mswd_rsp_if.source                        rsp_ch,
   input  logic                              csr_wr_en,
   input  logic [mswd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [mswd_pkg::CSR_DATA_W-1:0]   csr_wr_data
);

   localparam int ADDR_BITS = (MAX_SWITCHES > 1) ? $clog2(MAX_SWITCHES) : 1;

   // configuration registers
   logic [mswd_pkg::DEBOUNCE_W-1:0] debounce_ms_ff;
   logic [mswd_pkg::FIRST_W-1:0]    first_note_ff;
   logic [mswd_pkg::CHANNEL_W-1:0]  midi_channel_ff;
   logic [mswd_pkg::COUNT_W-1:0]    switch_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ms_ff  <= mswd_pkg::RST_DEBOUNCE_MS;
         first_note_ff   <= mswd_pkg::RST_FIRST_NOTE;
         midi_channel_ff <= mswd_pkg::RST_MIDI_CHANNEL;
         switch_count_ff <= mswd_pkg::RST_SWITCH_COUNT;
      end else if (csr_wr_en) begin
         case (csr_index)
            mswd_pkg::CSR_DEBOUNCE_MS: begin
               debounce_ms_ff <= csr_wr_data;
            end
            mswd_pkg::CSR_FIRST_NOTE: begin
               first_note_ff <= csr_wr_data[mswd_pkg::FIRST_W-1:0];
            end
            mswd_pkg::CSR_MIDI_CHANNEL: begin
               midi_channel_ff <= csr_wr_data[mswd_pkg::CHANNEL_W-1:0];
            end
            mswd_pkg::CSR_SWITCH_COUNT: begin
               switch_count_ff <= csr_wr_data[mswd_pkg::COUNT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // stage one: the request plus the stored word of its switch
   logic                          s1_valid_ff, s1_valid_in;
   logic                          s1_op_ff;
   logic [mswd_pkg::INDEX_W-1:0]  s1_idx_ff;
   logic                          s1_level_ff;
   logic                          rd_valid_ff;
   logic [TIME_BITS:0]            rd_word_ff;

   // per-switch {level, change time}, valid bits give the reset value
   logic [TIME_BITS:0]            switch_mem_ff [MAX_SWITCHES];
   logic [MAX_SWITCHES-1:0]       entry_valid_ff;

   logic [TIME_BITS-1:0]          now_ms_ff, now_ms_in;

   // result register
   logic                          res_valid_ff, res_valid_in;
   logic [mswd_pkg::NOTE_W-1:0]   res_note_ff;
   logic                          res_note_on_ff;
   logic [mswd_pkg::CHANNEL_W-1:0] res_channel_ff;

   logic                          req_accept;
   logic [ADDR_BITS-1:0]          new_addr;
   logic [ADDR_BITS-1:0]          s1_addr;
   logic                          in_use;
   logic                          st_level;
   logic [TIME_BITS-1:0]          st_time;
   logic [TIME_BITS-1:0]          elapsed;
   logic                          gives_result;
   logic                          out_free;
   logic                          s1_fire;
   logic                          wr_en;
   logic                          bypass;

   assign new_addr = ADDR_BITS'(req_ch.switch_index);
   assign s1_addr  = ADDR_BITS'(s1_idx_ff);

   // stored state of the switch in stage one
   assign st_level = rd_valid_ff ? rd_word_ff[TIME_BITS] : mswd_pkg::LEVEL_LOW;
   assign st_time  = rd_valid_ff ? rd_word_ff[TIME_BITS-1:0] : '0;

   // index in use: below switch_count and below the switch capacity
   assign in_use  = ({1'b0, s1_idx_ff} < switch_count_ff) && (32'(s1_idx_ff) < MAX_SWITCHES);
   // elapsed time wraps at the counter width
   assign elapsed = now_ms_ff - st_time;

   assign gives_result = s1_valid_ff && (s1_op_ff == mswd_pkg::OP_SAMPLE) && in_use
                       && (elapsed > TIME_BITS'(debounce_ms_ff))
                       && (st_level != s1_level_ff);

   assign out_free = !res_valid_ff || rsp_ch.ready;
   // ticks and rejected samples never wait on the result side
   assign s1_fire  = s1_valid_ff && (!gives_result || out_free);
   assign wr_en    = s1_fire && gives_result;

   assign req_ch.ready = !s1_valid_ff || s1_fire;
   assign req_accept   = req_ch.valid && req_ch.ready;

   // a write in this cycle to the switch being read wins over the memory
   assign bypass = wr_en && (s1_addr == new_addr);

   assign s1_valid_in = req_accept || (s1_valid_ff && !s1_fire);

   always_comb begin
      now_ms_in = now_ms_ff;
      if (s1_fire && (s1_op_ff == mswd_pkg::OP_TICK)) begin
         now_ms_in = now_ms_ff + TIME_BITS'(1);
      end
   end

   always_comb begin
      res_valid_in = res_valid_ff;
      if (wr_en) begin
         res_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         res_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         res_valid_ff   <= 1'b0;
         now_ms_ff      <= '0;
         entry_valid_ff <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         res_valid_ff <= res_valid_in;
         now_ms_ff    <= now_ms_in;
         if (wr_en) begin
            entry_valid_ff[s1_addr] <= 1'b1;
         end
      end
   end

   // request capture and switch memory read
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_op_ff    <= req_ch.op;
         s1_idx_ff   <= req_ch.switch_index;
         s1_level_ff <= req_ch.level;
         if (bypass) begin
            rd_word_ff  <= {s1_level_ff, now_ms_ff};
            rd_valid_ff <= 1'b1;
         end else begin
            rd_word_ff  <= switch_mem_ff[new_addr];
            rd_valid_ff <= entry_valid_ff[new_addr];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         switch_mem_ff[s1_addr] <= {s1_level_ff, now_ms_ff};
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (wr_en) begin
         res_note_ff    <= mswd_pkg::NOTE_W'(first_note_ff) + mswd_pkg::NOTE_W'(s1_idx_ff);
         res_note_on_ff <= (s1_level_ff == mswd_pkg::LEVEL_LOW);
         res_channel_ff <= midi_channel_ff;
      end
   end

   assign rsp_ch.valid       = res_valid_ff;
   assign rsp_ch.note_number = res_note_ff;
   assign rsp_ch.note_on     = res_note_on_ff;
   assign rsp_ch.velocity    = mswd_pkg::FIXED_VELOCITY;
   assign rsp_ch.channel     = res_channel_ff;

`ifndef NO_ASSERTIONS
   // a new event never overwrites one that is still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> out_free)
      else $error("event written over a waiting result");

   // a stage one request that does not move blocks new requests
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_fire) |-> !req_ch.ready)
      else $error("request taken while stage one is stalled");

   // a taken change marks its switch entry valid
   a_entry_marked: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> entry_valid_ff[$past(s1_addr)])
      else $error("switch entry not marked after write");

   // results only come out of a taken change
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(res_valid_ff) |-> $past(wr_en))
      else $error("result without a taken change");
`endif

endmodule
